### rtl/mnh_pkg.sv
// Package for the MurmurHash3 name hasher: hash constants, widths and the
// command record passed from the front end to the back end. No dependencies.
package mnh_pkg;

  localparam int unsigned LenBits  = 16;  // stored length width, 8..16 here
  localparam int unsigned TagW     = 22;
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = 1;
  localparam int unsigned CmdCntW  = 2;

  localparam logic [31:0] C1   = 32'hcc9e2d51;
  localparam logic [31:0] C2   = 32'h1b873593;
  localparam logic [31:0] MixN = 32'he6546b64;
  localparam logic [31:0] F1   = 32'h85ebca6b;
  localparam logic [31:0] F2   = 32'hc2b2ae35;
  localparam logic [13:0] TagScale = 14'd10000;

  typedef struct packed {
    logic [31:0]        word;      // block word, or masked tail
    logic               mix_block;
    logic               mix_tail;
    logic               seed;      // load accumulator with len first
    logic               last;      // finalise and emit
    logic [LenBits-1:0] len;
    logic [TagW-1:0]    tag;
  } cmd_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

endpackage

### rtl/mnh_front.sv
// Front end: takes input words, keeps length, first byte and previous top
// byte, and turns each word into a command. Depends on mnh_pkg.
module mnh_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [31:0]             data_word_i,
  input  logic [2:0]              byte_count_i,
  input  logic                    first_item_i,
  input  logic                    last_item_i,
  input  logic [15:0]             message_length_i,
  output mnh_pkg::cmd_t           cmd_o
);

  logic [mnh_pkg::LenBits-1:0] len_q, len_d;
  logic [7:0]  lead_q, lead_d;
  logic [7:0]  ptop_q, ptop_d;
  logic [7:0]  ptop_eff, lastb;
  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [mnh_pkg::TagW-1:0] lead_scaled;

  always_comb begin
    cnt      = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    len_d    = first_item_i ? message_length_i[mnh_pkg::LenBits-1:0] : len_q;
    lead_d   = first_item_i ? data_word_i[7:0] : lead_q;
    ptop_eff = first_item_i ? 8'd0 : ptop_q;
    ptop_d   = last_item_i ? ptop_eff : data_word_i[31:24];

    case (cnt)
      3'd1: begin
        mask  = 32'h0000_00ff;
        lastb = data_word_i[7:0];
      end
      3'd2: begin
        mask  = 32'h0000_ffff;
        lastb = data_word_i[15:8];
      end
      3'd3: begin
        mask  = 32'h00ff_ffff;
        lastb = data_word_i[23:16];
      end
      3'd4: begin
        mask  = 32'hffff_ffff;
        lastb = data_word_i[31:24];
      end
      default: begin
        mask  = 32'h0000_0000;
        lastb = ptop_eff;
      end
    endcase

    lead_scaled = mnh_pkg::TagW'(lead_d) * mnh_pkg::TagW'(mnh_pkg::TagScale);

    cmd_o.word      = last_item_i ? (data_word_i & mask) : data_word_i;
    // non-last words are always mixed as full blocks
    cmd_o.mix_block = !last_item_i || (cnt == 3'd4);
    cmd_o.mix_tail  = last_item_i && (cnt != 3'd4) && (cnt != 3'd0);
    cmd_o.seed      = first_item_i;
    cmd_o.last      = last_item_i;
    cmd_o.len       = len_d;
    cmd_o.tag       = lead_scaled + mnh_pkg::TagW'(lastb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      lead_q <= '0;
      ptop_q <= '0;
    end else if (take_i) begin
      len_q  <= len_d;
      lead_q <= lead_d;
      ptop_q <= ptop_d;
    end
  end

endmodule

### rtl/mnh_cmd_fifo.sv
// Short command queue between front and back end, so each side stalls on
// its own. Depends on mnh_pkg.
module mnh_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mnh_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output mnh_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  mnh_pkg::cmd_t entries_q [mnh_pkg::CmdDepth];
  logic [mnh_pkg::CmdPtrW-1:0] wptr_q, rptr_q;
  logic [mnh_pkg::CmdCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == mnh_pkg::CmdCntW'(mnh_pkg::CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/mnh_back.sv
// Back end: sequencer around one shared 32x32 multiplier that mixes blocks,
// tails and finalises, plus the result register. Depends on mnh_pkg.
module mnh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  mnh_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [31:0]   hash_value_o,
  output logic [mnh_pkg::TagW-1:0] name_tag_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StK1   = 3'd1;
  localparam logic [2:0] StK2   = 3'd2;
  localparam logic [2:0] StMix  = 3'd3;
  localparam logic [2:0] StFin1 = 3'd4;
  localparam logic [2:0] StFin2 = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [31:0] k_q, k_d;
  mnh_pkg::cmd_t cur_q, cur_d;
  logic        ovalid_q, ovalid_d;
  logic [31:0] ohash_q, ohash_d;
  logic [mnh_pkg::TagW-1:0] otag_q, otag_d;

  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] fin_t, fin_u, mix_x, h_final;

  always_comb begin
    fin_t   = h_q ^ 32'(cur_q.len);
    fin_t   = fin_t ^ (fin_t >> 16);
    fin_u   = h_q ^ (h_q >> 13);
    mix_x   = mnh_pkg::rotl13(h_q ^ k_q);
    h_final = h_q ^ (h_q >> 16);

    case (state_q)
      StK1: begin
        mul_a = k_q;
        mul_b = mnh_pkg::C1;
      end
      StK2: begin
        mul_a = mnh_pkg::rotl15(k_q);
        mul_b = mnh_pkg::C2;
      end
      StFin1: begin
        mul_a = fin_t;
        mul_b = mnh_pkg::F1;
      end
      default: begin
        mul_a = fin_u;
        mul_b = mnh_pkg::F2;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    k_d       = k_q;
    cur_d     = cur_q;
    ovalid_d  = ovalid_q && !pop_i;
    ohash_d   = ohash_q;
    otag_d    = otag_q;
    cmd_pop_o = 1'b0;

    case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          k_d       = cmd_i.word;
          if (cmd_i.seed) begin
            h_d = 32'(cmd_i.len);
          end
          if (cmd_i.mix_block || cmd_i.mix_tail) begin
            state_d = StK1;
          end else if (cmd_i.last) begin
            state_d = StFin1;
          end
        end
      end
      StK1: begin
        k_d     = prod;
        state_d = StK2;
      end
      StK2: begin
        k_d     = prod;
        state_d = StMix;
      end
      StMix: begin
        // tail: xor only; block: rotate, times five, add
        if (cur_q.mix_block) begin
          h_d = {mix_x[29:0], 2'b00} + mix_x + mnh_pkg::MixN;
        end else begin
          h_d = h_q ^ k_q;
        end
        state_d = cur_q.last ? StFin1 : StIdle;
      end
      StFin1: begin
        h_d     = prod;
        state_d = StFin2;
      end
      StFin2: begin
        h_d     = prod;
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || pop_i) begin
          ovalid_d = 1'b1;
          ohash_d  = h_final;
          otag_d   = cur_q.tag;
          h_d      = h_final;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      h_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      h_q      <= h_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    cur_q   <= cur_d;
    ohash_q <= ohash_d;
    otag_q  <= otag_d;
  end

  assign empty_o      = !ovalid_q;
  assign hash_value_o = ohash_q;
  assign name_tag_o   = otag_q;

endmodule

### rtl/murmur3_name_hasher.sv
// MurmurHash3 x86 32-bit name hasher, seeded with the message length.
// Each word passes the front end and the command queue; the back end then
// pops it and runs two scramble multiplies and a mix step for a full word or
// tail, and for a last item two finalise multiplies and the output step, all
// on the shared multiplier; it pops the next command only once back in idle,
// and the output step holds while an earlier result waits for pop.
// Reset: asynchronous; clears accumulator, stored length, first byte, queues.
module murmur3_name_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  input  logic [15:0] message_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value_o,
  output logic [21:0] name_tag_o
);

  mnh_pkg::cmd_t front_cmd, back_cmd;
  logic cmd_full, cmd_empty, cmd_pop;

  assign full = cmd_full;

  mnh_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (push && !cmd_full),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .first_item_i     (first_item_i),
    .last_item_i      (last_item_i),
    .message_length_i (message_length_i),
    .cmd_o            (front_cmd)
  );

  mnh_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (cmd_pop),
    .rdata_o (back_cmd),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  mnh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (back_cmd),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o),
    .name_tag_o   (name_tag_o)
  );

endmodule

### rtl/mnh_checker.sv
// Port-level checker for the name hasher, bound to the top level.
// Depends only on the top-level ports.
module mnh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] hash_value_o,
  input logic [21:0] name_tag_o
);

  // a waiting result is not withdrawn and does not change
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hash_value_o) && $stable(name_tag_o)))
    else $error("result changed or vanished before transfer");

  // tag is last byte plus 10000 times first byte, so bounded
  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (name_tag_o <= 22'd2550255))
    else $error("name tag out of range");

  // queues come out of reset empty
  a_reset_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (empty && !full))
    else $error("queues not clear after reset");

  // the input queue only fills up through a transfer in
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full && !push) |=> !full)
    else $error("full rose without a transfer");

endmodule

bind murmur3_name_hasher mnh_checker u_mnh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .hash_value_o (hash_value_o),
  .name_tag_o   (name_tag_o)
);

### tb/sv/mnh_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the MurmurHash3 name hasher testbench: a predictor of the
// hash and name tag, and the queue of digests still due. Uses mnh_pkg widths.
package mnh_tb_pkg;

  localparam logic [31:0] MIX_K1    = 32'hcc9e2d51;
  localparam logic [31:0] MIX_K2    = 32'h1b873593;
  localparam logic [31:0] MIX_ADD   = 32'he6546b64;
  localparam logic [31:0] FMIX_K1   = 32'h85ebca6b;
  localparam logic [31:0] FMIX_K2   = 32'hc2b2ae35;
  localparam int unsigned TAG_STEP  = 10000;
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned SHOWN_MISMATCHES = 50;

  typedef struct {
    logic [31:0]              hash;
    logic [mnh_pkg::TagW-1:0] tag;
  } name_digest_t;

  class name_hash_board;
    logic [31:0]                 acc;
    logic [mnh_pkg::LenBits-1:0] len_q;
    logic [7:0]                  head_byte;
    logic [7:0]                  prev_top;
    name_digest_t                pending[$];
    int unsigned                 errors;

    function new();
      acc       = '0;
      len_q     = '0;
      head_byte = '0;
      prev_top  = '0;
      errors    = 0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] scramble(logic [31:0] k);
      k = k * MIX_K1;
      k = rotl(k, 15);
      return k * MIX_K2;
    endfunction

    function logic [31:0] mix(logic [31:0] h, logic [31:0] k);
      h ^= scramble(k);
      h = rotl(h, 13);
      return h * 32'd5 + MIX_ADD;
    endfunction

    // Called once per input transfer; queues a digest on a last item.
    function void note_word(logic [31:0] word, logic [2:0] cnt_raw, logic first,
                            logic last, logic [15:0] len);
      int unsigned  cnt;
      logic [31:0]  h;
      logic [31:0]  mask;
      logic [7:0]   tail_byte;
      name_digest_t d;
      cnt = (cnt_raw > WORD_BYTES) ? WORD_BYTES : cnt_raw;
      if (first) begin
        len_q     = len[mnh_pkg::LenBits-1:0];
        acc       = 32'(len_q);
        head_byte = word[7:0];
        prev_top  = '0;
      end
      if (!last) begin
        // short counts on non-last words are still mixed as full blocks
        acc      = mix(acc, word);
        prev_top = word[31:24];
        return;
      end
      h = acc;
      if (cnt == WORD_BYTES) begin
        h = mix(h, word);
      end else if (cnt != 0) begin
        mask = (32'h1 << (8 * cnt)) - 32'h1;
        h ^= scramble(word & mask);
      end
      tail_byte = (cnt == 0) ? prev_top : 8'(word >> (8 * (cnt - 1)));
      h ^= 32'(len_q);
      h ^= h >> 16;
      h = h * FMIX_K1;
      h ^= h >> 13;
      h = h * FMIX_K2;
      h ^= h >> 16;
      acc = h;
      d.hash = h;
      d.tag  = mnh_pkg::TagW'(int'(tail_byte) + TAG_STEP * int'(head_byte));
      pending.push_back(d);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= SHOWN_MISMATCHES) $display("mismatch: %s", msg);
    endtask

    task check_digest(logic [31:0] hash, logic [mnh_pkg::TagW-1:0] tag);
      name_digest_t d;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result hash %h tag %0d", hash, tag));
        return;
      end
      d = pending.pop_front();
      if (hash !== d.hash)
        report_mismatch($sformatf("hash_value %h, predicted %h", hash, d.hash));
      if (tag !== d.tag)
        report_mismatch($sformatf("name_tag %0d, predicted %0d", tag, d.tag));
    endtask
  endclass

endpackage

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for murmur3_name_hasher: drives names as word streams
// through the push side and checks digests on the pop side. Needs mnh_tb_pkg.
module tb;

  localparam int unsigned ITEM_TARGET  = 2000;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned BREAK_PCT    = 25;

  logic            clk_i            = 1'b0;
  logic            rst_ni           = 1'b0;
  logic            push             = 1'b0;
  logic            pop              = 1'b0;
  logic [31:0]     data_word_i      = '0;
  logic [2:0]      byte_count_i     = '0;
  logic            first_item_i     = 1'b0;
  logic            last_item_i      = 1'b0;
  logic [15:0]     message_length_i = '0;
  logic            full;
  logic            empty;
  logic [31:0]     hash_value_o;
  logic [mnh_pkg::TagW-1:0] name_tag_o;

  mnh_tb_pkg::name_hash_board board = new();
  int unsigned    items_sent  = 0;
  int unsigned    quiet_cycles = 0;
  bit             steady      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  murmur3_name_hasher u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .first_item_i     (first_item_i),
    .last_item_i      (last_item_i),
    .message_length_i (message_length_i),
    .empty            (empty),
    .pop              (pop),
    .hash_value_o     (hash_value_o),
    .name_tag_o       (name_tag_o)
  );

  function bit take_break();
    return !steady && ($urandom_range(0, 99) < BREAK_PCT);
  endfunction

  // Entered at a rising edge; returns at the edge of the transfer.
  task send_word(logic [31:0] word, logic [2:0] cnt, logic first, logic last,
                 logic [15:0] len);
    while (take_break()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    data_word_i      <= word;
    byte_count_i     <= cnt;
    first_item_i     <= first;
    last_item_i      <= last;
    message_length_i <= len;
    do @(posedge clk_i); while (full);
    board.note_word(word, cnt, first, last, len);
    items_sent++;
    steady = (items_sent >= 900) && (items_sent < 1200);
  endtask

  // Well-formed name of `actual` bytes; `declared` may disagree with it.
  task send_name(int unsigned actual, logic [15:0] declared, bit zero_tail);
    int unsigned rest;
    bit          first;
    rest  = actual;
    first = 1'b1;
    while (rest > mnh_tb_pkg::WORD_BYTES ||
           (rest == mnh_tb_pkg::WORD_BYTES && zero_tail)) begin
      send_word($urandom(), 3'(mnh_tb_pkg::WORD_BYTES), first, 1'b0, declared);
      rest -= mnh_tb_pkg::WORD_BYTES;
      first = 1'b0;
    end
    send_word($urandom(), 3'(rest), first, 1'b1, declared);
  endtask

  task send_noise();
    send_word($urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 16'($urandom()));
  endtask

  // Result side: check at the transfer edge, then pick the next pop.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) board.check_digest(hash_value_o, name_tag_o);
    pop <= steady || ($urandom_range(0, 99) >= BREAK_PCT);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // words ahead of any first item run on the reset state
    send_word(32'hffff_ffff, 3'd4, 1'b0, 1'b0, 16'h0000);
    send_word(32'h0000_0000, 3'd2, 1'b0, 1'b1, 16'hffff);
    // single-item names, then names of several words
    send_word(32'h0000_00ff, 3'd1, 1'b1, 1'b1, 16'd1);
    send_word(32'ha5a5_a5a5, 3'd0, 1'b1, 1'b1, 16'hffff);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 1'b1, 16'hffff);
    send_word(32'h8040_2010, 3'd7, 1'b1, 1'b1, 16'd4);
    send_name(5, 16'd5, 1'b0);
    send_name(8, 16'd8, 1'b1);
    send_name(7, 16'd7, 1'b0);
    // short and oversized counts on non-last words
    send_word(32'h1234_5678, 3'd2, 1'b1, 1'b0, 16'd9);
    send_word(32'hcafe_f00d, 3'd5, 1'b0, 1'b0, 16'd9);
    send_word(32'h0bad_beef, 3'd3, 1'b0, 1'b1, 16'd9);
    // length disagreeing with the words sent
    send_name(6, 16'd300, 1'b0);
    // empty last item straight after a finished name
    send_word(32'h0000_0000, 3'd0, 1'b0, 1'b1, 16'h0000);
    send_word(32'h7fff_fffe, 3'd6, 1'b0, 1'b1, 16'h8000);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 80) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 200)
                                           : $urandom_range(1, 24);
        send_name(len,
                  ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'(len),
                  (len % mnh_tb_pkg::WORD_BYTES == 0) && $urandom_range(0, 1));
      end else begin
        send_noise();
      end
    end
    push <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/mnh_pkg.sv
rtl/mnh_front.sv
rtl/mnh_cmd_fifo.sv
rtl/mnh_back.sv
rtl/murmur3_name_hasher.sv
rtl/mnh_checker.sv
tb/sv/mnh_tb_pkg.sv
tb/sv/tb.sv
